// ===== hw/rtl/tjq_pkg.sv =====
// ----------------------------------------------------------------------------
// tjq_pkg: shared types and constants of the timed job queue
// Slot pool geometry, field widths, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package tjq_pkg;

    localparam int SLOTS     = 32;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int LINK_BITS = SLOT_BITS + 1;
    localparam int TIME_BITS = 48;
    localparam int PER_BITS  = 32;
    localparam int TAG_BITS  = 16;
    localparam int CNT_BITS  = $clog2(TIME_BITS + 1);

    localparam logic [LINK_BITS-1:0] NONE_SLOT = LINK_BITS'(SLOTS);
    localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ONCE     = 2'd0;
    localparam t_cmd CMD_PERIODIC = 2'd1;
    localparam t_cmd CMD_DISPATCH = 2'd2;
    localparam t_cmd CMD_DONE     = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_QUEUED     = 3'd0;
    localparam t_status ST_DISPATCHED = 3'd1;
    localparam t_status ST_NOTHING    = 3'd2;
    localparam t_status ST_FULL       = 3'd3;
    localparam t_status ST_BAD        = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_ALLOC_RQ,
        S_ALLOC,
        S_DISP,
        S_COMP,
        S_WALK_RQ,
        S_WALK,
        S_LINK,
        S_LINK2,
        S_RESULT
    } t_state;

endpackage

// ===== hw/rtl/tjq_div.sv =====
// ----------------------------------------------------------------------------
// tjq_div: next interval multiple
// Restoring remainder, one dividend bit per cycle, then align and saturate.
// ----------------------------------------------------------------------------
module tjq_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tjq_pkg::TIME_BITS-1:0] i_now,
    input  logic [tjq_pkg::PER_BITS-1:0]  i_per,
    output logic                          o_done,
    output logic [tjq_pkg::TIME_BITS-1:0] o_next
);
    import tjq_pkg::*;

    logic                  r_busy, r_fin, r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [PER_BITS-1:0]   r_rem, r_per;
    logic [TIME_BITS-1:0]  r_num, r_now, r_next;
    logic [PER_BITS:0]     trial;
    logic [TIME_BITS-1:0]  base;
    logic [TIME_BITS:0]    sum;

    assign trial = {r_rem, r_num[TIME_BITS-1]};
    assign base  = r_now - TIME_BITS'(r_rem);
    assign sum   = {1'b0, base} + (TIME_BITS+1)'(r_per);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_BITS'(TIME_BITS - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_num <= i_now;
            r_now <= i_now;
            r_per <= i_per;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_num <= {r_num[TIME_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_per}) begin
                r_rem <= PER_BITS'(trial - {1'b0, r_per});
            end else begin
                r_rem <= trial[PER_BITS-1:0];
            end
        end
        if (r_fin) begin
            r_next <= sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_next = r_next;

endmodule

// ===== hw/rtl/timed_job_queue.sv =====
// ----------------------------------------------------------------------------
// timed_job_queue: deadline-ordered job slot pool
// Sorted linked list of slots, a free list, and a sequencer over slot memories.
// ----------------------------------------------------------------------------
// Rejected requests and empty dispatches go straight to the result; a schedule
// walks the sorted list entry by entry (at most SLOTS entries), and periodic
// schedules and completions first run the remainder unit before the walk.
// The block takes one transaction at a time; the next is taken the cycle after the
// result is accepted. Reset: list empty, all slots free, no job busy; no clearing pass.
module timed_job_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [tjq_pkg::TIME_BITS-1:0] i_time_now,
    input  logic [tjq_pkg::PER_BITS-1:0]  i_interval,
    input  logic [tjq_pkg::TAG_BITS-1:0]  i_job_id,
    input  logic [tjq_pkg::SLOT_BITS-1:0] i_slot_ref,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [tjq_pkg::TAG_BITS-1:0]  o_out_job_id,
    output logic [tjq_pkg::SLOT_BITS-1:0] o_out_slot,
    output logic [tjq_pkg::TIME_BITS-1:0] o_out_deadline
);
    import tjq_pkg::*;

    t_state r_state, n_state;

    logic [TIME_BITS-1:0] dl_mem  [SLOTS];
    logic [PER_BITS-1:0]  per_mem [SLOTS];
    logic [TAG_BITS-1:0]  tag_mem [SLOTS];
    logic [LINK_BITS-1:0] link_mem[SLOTS];
    logic [SLOTS-1:0]     r_link_vld;
    logic [SLOTS-1:0]     r_busy_flags;

    logic [TIME_BITS-1:0] r_dl_rd;
    logic [PER_BITS-1:0]  r_per_rd;
    logic [TAG_BITS-1:0]  r_tag_rd;
    logic [LINK_BITS-1:0] r_link_rd;
    logic                 r_link_rv;
    logic [SLOT_BITS-1:0] r_link_ra;
    logic [LINK_BITS-1:0] link_q;

    logic [1:0]           r_cmd;
    logic [TIME_BITS-1:0] r_now, r_dl;
    logic [PER_BITS-1:0]  r_per;
    logic [TAG_BITS-1:0]  r_tag;
    logic [SLOT_BITS-1:0] r_sref, r_slot;
    logic [LINK_BITS-1:0] r_head, r_free, r_cur, r_prev, r_steps;

    logic [2:0]           r_status;
    logic [TAG_BITS-1:0]  r_o_tag;
    logic [SLOT_BITS-1:0] r_o_slot;
    logic [TIME_BITS-1:0] r_o_dl;

    logic [SLOT_BITS-1:0] rd_addr;
    logic                 dl_we, lk_we;
    logic [SLOT_BITS-1:0] lk_wa;
    logic [LINK_BITS-1:0] lk_wd;

    logic                 div_start;
    logic                 div_done;
    logic [PER_BITS-1:0]  div_per;
    logic [TIME_BITS-1:0] div_next;

    logic take, give, sref_bad;

    assign take     = (r_state == S_IDLE) && i_valid;
    assign give     = (r_state == S_RESULT) && !i_stall;
    assign link_q   = r_link_rv ? r_link_rd : LINK_BITS'(r_link_ra) + 1'b1;
    assign sref_bad = ({1'b0, r_sref} >= NONE_SLOT) || !r_busy_flags[r_sref];

    tjq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_now   (r_now),
        .i_per   (div_per),
        .o_done  (div_done),
        .o_next  (div_next)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_valid) n_state = S_DECODE;
            S_DECODE: begin
                unique case (r_cmd)
                    CMD_ONCE:     n_state = S_ALLOC_RQ;
                    CMD_PERIODIC: n_state = (r_per == '0) ? S_RESULT : S_DIV;
                    CMD_DISPATCH: n_state = (r_head == NONE_SLOT) ? S_RESULT : S_DISP;
                    default:      n_state = sref_bad ? S_RESULT : S_COMP;
                endcase
            end
            S_DIV:      if (div_done) n_state = (r_cmd == CMD_DONE) ? S_WALK_RQ : S_ALLOC_RQ;
            S_ALLOC_RQ: n_state = (r_free == NONE_SLOT) ? S_RESULT : S_ALLOC;
            S_ALLOC:    n_state = S_WALK_RQ;
            S_DISP:     n_state = S_RESULT;
            S_COMP:     n_state = (r_per_rd != '0) ? S_DIV : S_RESULT;
            S_WALK_RQ:  n_state = (r_cur == NONE_SLOT || r_steps == NONE_SLOT) ? S_LINK : S_WALK;
            S_WALK:     n_state = (r_dl < r_dl_rd) ? S_LINK : S_WALK_RQ;
            S_LINK:     n_state = S_LINK2;
            S_LINK2:    n_state = S_RESULT;
            S_RESULT:   if (!i_stall) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rd_addr   = r_cur[SLOT_BITS-1:0];
        dl_we     = 1'b0;
        lk_we     = 1'b0;
        lk_wa     = r_slot;
        lk_wd     = r_cur;
        div_start = 1'b0;
        div_per   = r_per;
        unique case (r_state)
            S_DECODE: begin
                rd_addr   = (r_cmd == CMD_DISPATCH) ? r_head[SLOT_BITS-1:0] : r_sref;
                div_start = (r_cmd == CMD_PERIODIC) && (r_per != '0);
            end
            S_ALLOC_RQ: rd_addr = r_free[SLOT_BITS-1:0];
            S_ALLOC:    dl_we   = 1'b1;
            S_COMP: begin
                div_start = (r_per_rd != '0);
                div_per   = r_per_rd;
                lk_we     = (r_per_rd == '0);
                lk_wd     = r_free;
            end
            S_DIV:   dl_we = div_done && (r_cmd == CMD_DONE);
            S_LINK:  lk_we = 1'b1;
            S_LINK2: begin
                lk_we = (r_prev != NONE_SLOT);
                lk_wa = r_prev[SLOT_BITS-1:0];
                lk_wd = LINK_BITS'(r_slot);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_dl_rd   <= dl_mem[rd_addr];
        r_per_rd  <= per_mem[rd_addr];
        r_tag_rd  <= tag_mem[rd_addr];
        r_link_rd <= link_mem[rd_addr];
        r_link_rv <= r_link_vld[rd_addr];
        r_link_ra <= rd_addr;
        if (dl_we) begin
            dl_mem[r_slot] <= (r_state == S_DIV) ? div_next : r_dl;
        end
        if (r_state == S_ALLOC) begin
            per_mem[r_slot] <= r_per;
            tag_mem[r_slot] <= r_tag;
        end
        if (lk_we) begin
            link_mem[lk_wa] <= lk_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_link_vld   <= '0;
            r_busy_flags <= '0;
            r_head       <= NONE_SLOT;
            r_free       <= '0;
        end else begin
            r_state <= n_state;
            if (lk_we) begin
                r_link_vld[lk_wa] <= 1'b1;
            end
            unique case (r_state)
                S_ALLOC: begin
                    r_free                 <= link_q;
                    r_busy_flags[r_slot]   <= 1'b0;
                end
                S_DISP: begin
                    if (!(r_now < r_dl_rd)) begin
                        r_head                 <= link_q;
                        r_busy_flags[r_slot]   <= 1'b1;
                    end
                end
                S_COMP: begin
                    r_busy_flags[r_slot] <= 1'b0;
                    if (r_per_rd == '0) begin
                        r_free <= LINK_BITS'(r_slot);
                    end
                end
                S_LINK2: begin
                    if (r_prev == NONE_SLOT) begin
                        r_head <= LINK_BITS'(r_slot);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd  <= i_cmd;
            r_now  <= i_time_now;
            r_per  <= (i_cmd == CMD_ONCE) ? '0 : i_interval;
            r_tag  <= i_job_id;
            r_sref <= i_slot_ref;
            r_dl   <= i_time_now;
        end
        unique case (r_state)
            S_DECODE: begin
                r_slot   <= (r_cmd == CMD_DISPATCH) ? r_head[SLOT_BITS-1:0] : r_sref;
                r_status <= ST_BAD;
                r_o_tag  <= '0;
                r_o_slot <= '0;
                r_o_dl   <= '0;
                if (r_cmd == CMD_DISPATCH) begin
                    r_status <= ST_NOTHING;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_dl    <= div_next;
                    r_cur   <= r_head;
                    r_prev  <= NONE_SLOT;
                    r_steps <= '0;
                end
            end
            S_ALLOC_RQ: begin
                r_slot   <= r_free[SLOT_BITS-1:0];
                r_status <= ST_FULL;
            end
            S_ALLOC: begin
                r_cur   <= r_head;
                r_prev  <= NONE_SLOT;
                r_steps <= '0;
            end
            S_DISP: begin
                if (!(r_now < r_dl_rd)) begin
                    r_status <= ST_DISPATCHED;
                    r_o_tag  <= r_tag_rd;
                    r_o_slot <= r_slot;
                    r_o_dl   <= r_dl_rd;
                end
            end
            S_COMP: begin
                r_per    <= r_per_rd;
                r_tag    <= r_tag_rd;
                r_status <= ST_NOTHING;
            end
            S_WALK: begin
                if (!(r_dl < r_dl_rd)) begin
                    r_prev  <= r_cur;
                    r_cur   <= link_q;
                    r_steps <= r_steps + 1'b1;
                end
            end
            S_LINK2: begin
                r_status <= ST_QUEUED;
                r_o_tag  <= r_tag;
                r_o_slot <= r_slot;
                r_o_dl   <= r_dl;
            end
            default: ;
        endcase
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_RESULT);
    assign o_status       = r_status;
    assign o_out_job_id   = r_o_tag;
    assign o_out_slot     = r_o_slot;
    assign o_out_deadline = r_o_dl;

endmodule

// ===== tb/timed_job_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_job_queue_checker: result predictor and scoreboard
// Watches the input and output channels of the queue, keeps its own copy of
// the slot lists, computes the expected result of every transaction and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module timed_job_queue_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_stall_in,
    input  logic [1:0]                     i_cmd,
    input  logic [tjq_pkg::TIME_BITS-1:0]  i_time_now,
    input  logic [tjq_pkg::PER_BITS-1:0]   i_interval,
    input  logic [tjq_pkg::TAG_BITS-1:0]   i_job_id,
    input  logic [tjq_pkg::SLOT_BITS-1:0]  i_slot_ref,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [2:0]                     i_status,
    input  logic [tjq_pkg::TAG_BITS-1:0]   i_out_job_id,
    input  logic [tjq_pkg::SLOT_BITS-1:0]  i_out_slot,
    input  logic [tjq_pkg::TIME_BITS-1:0]  i_out_deadline,
    output int                             o_errors,
    output int                             o_pending
);
    import tjq_pkg::*;

    typedef struct packed {
        logic [2:0]           status;
        logic [TAG_BITS-1:0]  tag;
        logic [SLOT_BITS-1:0] slot;
        logic [TIME_BITS-1:0] deadline;
    } t_result;

    logic [TIME_BITS-1:0] m_deadline [SLOTS];
    logic [PER_BITS-1:0]  m_period   [SLOTS];
    logic [TAG_BITS-1:0]  m_tag      [SLOTS];
    int                   m_link     [SLOTS];
    logic                 m_busy     [SLOTS];
    int                   m_head;
    int                   m_free;
    t_result              expected_q [$];

    assign o_pending = expected_q.size();

    function automatic logic [TIME_BITS-1:0] next_deadline(logic [TIME_BITS-1:0] now,
                                                           logic [PER_BITS-1:0] per);
        logic [TIME_BITS:0] base;
        base = (now / per) * per;
        if (base > {1'b0, TIME_MAX} - per) return TIME_MAX;
        return base[TIME_BITS-1:0] + per;
    endfunction

    function automatic void insert_sorted(int s);
        int prev;
        int cur;
        prev = SLOTS;
        cur  = m_head;
        while (cur < SLOTS && !(m_deadline[s] < m_deadline[cur])) begin
            prev = cur;
            cur  = m_link[cur];
        end
        m_link[s] = cur;
        if (prev < SLOTS) m_link[prev] = s;
        else m_head = s;
    endfunction

    function automatic t_result predict_queue(logic [1:0] cmd, logic [TIME_BITS-1:0] now,
                                              logic [PER_BITS-1:0] per,
                                              logic [TAG_BITS-1:0] tag,
                                              logic [SLOT_BITS-1:0] sref);
        t_result r;
        int s;
        logic [TIME_BITS-1:0] dl;
        r = '0;
        if (cmd == CMD_ONCE || cmd == CMD_PERIODIC) begin
            dl = now;
            if (cmd == CMD_PERIODIC) begin
                if (per == 0) begin
                    r.status = ST_BAD;
                    return r;
                end
                dl = next_deadline(now, per);
            end else begin
                per = 0;
            end
            if (m_free >= SLOTS) begin
                r.status = ST_FULL;
                return r;
            end
            s = m_free;
            m_free = m_link[s];
            m_deadline[s] = dl;
            m_period[s] = per;
            m_tag[s] = tag;
            m_busy[s] = 1'b0;
            insert_sorted(s);
            r = '{ST_QUEUED, tag, s[SLOT_BITS-1:0], dl};
        end else if (cmd == CMD_DISPATCH) begin
            s = m_head;
            if (s >= SLOTS || now < m_deadline[s]) begin
                r.status = ST_NOTHING;
                return r;
            end
            m_head = m_link[s];
            m_busy[s] = 1'b1;
            r = '{ST_DISPATCHED, m_tag[s], s[SLOT_BITS-1:0], m_deadline[s]};
        end else begin
            s = sref;
            if (!m_busy[s]) begin
                r.status = ST_BAD;
                return r;
            end
            m_busy[s] = 1'b0;
            if (m_period[s] != 0) begin
                m_deadline[s] = next_deadline(now, m_period[s]);
                insert_sorted(s);
                r = '{ST_QUEUED, m_tag[s], s[SLOT_BITS-1:0], m_deadline[s]};
            end else begin
                m_link[s] = m_free;
                m_free = s;
                r.status = ST_NOTHING;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        for (int i = 0; i < SLOTS; i++) begin
            m_link[i] = i + 1;
            m_busy[i] = 1'b0;
        end
        m_head = SLOTS;
        m_free = 0;
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in)
                expected_q.push_back(predict_queue(i_cmd, i_time_now, i_interval,
                                                   i_job_id, i_slot_ref));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", i_status, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (i_status !== e.status) report_mismatch("status", i_status, e.status);
                    if (i_out_job_id !== e.tag) report_mismatch("job_id", i_out_job_id, e.tag);
                    if (i_out_slot !== e.slot) report_mismatch("slot", i_out_slot, e.slot);
                    if (i_out_deadline !== e.deadline)
                        report_mismatch("deadline", i_out_deadline, e.deadline);
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the timed job queue
// Drives directed and random schedule, dispatch and completion transactions
// with random idling on both channels, a long output hold-off that fills the
// block, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import tjq_pkg::*;

    localparam int LIMIT = 2000000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            cmd;
    logic [TIME_BITS-1:0]  time_now;
    logic [PER_BITS-1:0]   interval;
    logic [TAG_BITS-1:0]   job_id;
    logic [SLOT_BITS-1:0]  slot_ref;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            status;
    logic [TAG_BITS-1:0]   out_job_id;
    logic [SLOT_BITS-1:0]  out_slot;
    logic [TIME_BITS-1:0]  out_deadline;
    int                    errors;
    int                    pending;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    hold_cycles;
    int                    cycles;
    logic [TIME_BITS-1:0]  clock_ticks;
    int                    live_slots [$];

    timed_job_queue u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_cmd(cmd), .i_time_now(time_now), .i_interval(interval),
        .i_job_id(job_id), .i_slot_ref(slot_ref), .o_valid(out_valid),
        .i_stall(out_stall), .o_status(status), .o_out_job_id(out_job_id),
        .o_out_slot(out_slot), .o_out_deadline(out_deadline)
    );

    timed_job_queue_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_cmd(cmd), .i_time_now(time_now), .i_interval(interval),
        .i_job_id(job_id), .i_slot_ref(slot_ref), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_status(status), .i_out_job_id(out_job_id),
        .i_out_slot(out_slot), .i_out_deadline(out_deadline),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** timed_job_queue: FAILED **");
            $finish;
        end
    end

    // receiver: random stall, or a counted hold-off
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // track dispatched slots so completions mostly name busy ones
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall && status == ST_DISPATCHED)
            live_slots.push_back(out_slot);
    end

    task automatic send_job(logic [1:0] c, logic [TIME_BITS-1:0] t,
                            logic [PER_BITS-1:0] per, logic [TAG_BITS-1:0] tag,
                            logic [SLOT_BITS-1:0] sref);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        time_now <= t;
        interval <= per;
        job_id   <= tag;
        slot_ref <= sref;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        int pick;
        int idx;
        logic [SLOT_BITS-1:0] sref;
        logic [PER_BITS-1:0] per;
        pick = $urandom_range(99);
        clock_ticks = clock_ticks + $urandom_range(40);
        per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 200);
        if ($urandom_range(30) == 0) per = 0;
        if (pick < 25) begin
            send_job(CMD_ONCE, ($urandom_range(15) == 0) ? TIME_BITS'({$urandom, $urandom}) :
                     clock_ticks + $urandom_range(300), 32'($urandom), 16'($urandom),
                     5'($urandom));
        end else if (pick < 45) begin
            send_job(CMD_PERIODIC,
                     ($urandom_range(20) == 0) ? TIME_BITS'({$urandom, $urandom}) :
                     clock_ticks, per, 16'($urandom), 5'($urandom));
        end else if (pick < 75) begin
            send_job(CMD_DISPATCH, ($urandom_range(20) == 0) ? TIME_MAX : clock_ticks,
                     32'($urandom), 16'($urandom), 5'($urandom));
        end else begin
            sref = 5'($urandom);
            if (live_slots.size() > 0 && $urandom_range(9) < 8) begin
                idx  = $urandom_range(live_slots.size() - 1);
                sref = SLOT_BITS'(live_slots[idx]);
                live_slots.delete(idx);
            end
            send_job(CMD_DONE,
                     ($urandom_range(20) == 0) ? TIME_BITS'({$urandom, $urandom}) :
                     clock_ticks, 32'($urandom), 16'($urandom), sref);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_ONCE;
        time_now = '0;
        interval = '0;
        job_id = '0;
        slot_ref = '0;
        out_stall = 1'b0;
        hold_cycles = 0;
        cycles = 0;
        clock_ticks = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty dispatch, bad completions, extremes, saturation, full pool
        send_job(CMD_DISPATCH, TIME_MAX, '1, '1, '1);
        send_job(CMD_DONE, '0, '0, '0, 5'd0);
        send_job(CMD_DONE, '0, '0, '0, 5'd31);
        send_job(CMD_PERIODIC, 48'd100, '0, 16'h1234, '0);
        send_job(CMD_ONCE, 48'd0, '0, 16'h0000, '0);
        send_job(CMD_ONCE, TIME_MAX, '1, 16'hffff, '1);
        send_job(CMD_PERIODIC, TIME_MAX - 5, 32'd7, 16'hbeef, '0);
        send_job(CMD_PERIODIC, 48'd10, 32'hffffffff, 16'h5555, '0);
        send_job(CMD_ONCE, 48'd50, '0, 16'haaaa, '0);
        send_job(CMD_ONCE, 48'd50, '0, 16'h5555, '0);
        send_job(CMD_DISPATCH, 48'd0, '0, '0, '0);
        send_job(CMD_DISPATCH, 48'd49, '0, '0, '0);
        send_job(CMD_DISPATCH, 48'd50, '0, '0, '0);
        send_job(CMD_DONE, 48'd60, '0, '0, 5'd4);
        send_job(CMD_DONE, 48'd60, '0, '0, 5'd4);
        for (int i = 0; i < 30; i++)
            send_job(CMD_ONCE, 48'(i * 3), '0, 16'(i), '0);
        send_job(CMD_PERIODIC, 48'd5, 32'd3, 16'h0101, '0);
        send_job(CMD_DISPATCH, TIME_MAX, '0, '0, '0);
        send_job(CMD_DONE, 48'd99, '0, '0, 5'd4);
        for (int i = 0; i < 34; i++)
            send_job(CMD_DISPATCH, TIME_MAX, '0, '0, '0);
        in_valid <= 1'b0;
        while (pending > 0) @(posedge clk);
        @(negedge clk);
        live_slots.delete();
        for (int i = 0; i < SLOTS; i++) send_job(CMD_DONE, TIME_MAX, '0, '0, 5'(i));

        // pressure: hold the output while offering transactions
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) send_random();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 71 : 0;
            recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 36 : 0;
            for (int i = 0; i < 420; i++) send_random();
        end

        in_valid <= 1'b0;
        while (pending > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("** timed_job_queue: PASSED **");
        else
            $display("** timed_job_queue: FAILED **");
        $finish;
    end

endmodule
